### src/qau_pkg.sv
// Shared constants and opcode type for the quaternion arithmetic unit.
// No dependencies; imported by quaternion_arithmetic_unit.
package qau_pkg;

    localparam int OP_W       = 4;
    localparam int THRESH_W   = 25;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 25'd168;
    localparam int NORM_GUARD = 8;
    localparam int SQRT_SHIFT = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_SCALE   = 4'd3,
        OP_DOT     = 4'd4,
        OP_NORM    = 4'd5,
        OP_INV     = 4'd6,
        OP_DIV     = 4'd7,
        OP_CLOSEST = 4'd8,
        OP_LERP    = 4'd9
    } op_t;

endpackage

### src/quaternion_arithmetic_unit.sv
// Quaternion arithmetic unit: fully pipelined datapath with square root and divider.
// Depends on qau_pkg (opcodes, threshold width and reset, guard and shift constants).
//
// Usage:
//   Input channel in_valid/in_ready carries one item: opcode, quaternions p and q, factor.
//   Output channel out_valid/out_ready returns one result item per input item, in order:
//   r_x..r_w, dot_value and the saturated and degenerate flags.
//   Configuration channel cfg_valid/cfg_ready writes norm_threshold; cfg_ready is always
//   high and the write is expected only while no item is in flight.
//   Throughput: one item per cycle while the receiver does not stall. RW = COMPONENT_BITS + 9
//   is the number of square root stages (one root bit each) and NW is the number of divider
//   stages (one quotient bit each); with the default parameters RW = 25 and NW = 41.
//   The divider is shared by normalize, inverse and divide; the Hamilton product stage
//   after it serves multiply and divide.
//   Reset clears every valid bit and loads norm_threshold with its reset value 168.
//   When the receiver stalls the whole pipeline holds, in_ready drops, and nothing is lost
//   or repeated; empty stages still fill while the output register is empty.
module quaternion_arithmetic_unit #(
    parameter int COMPONENT_BITS = 16,
    parameter int FRACTION_BITS  = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qau_pkg::THRESH_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [qau_pkg::OP_W-1:0]            opcode,
    input  logic signed [COMPONENT_BITS-1:0]    p_x,
    input  logic signed [COMPONENT_BITS-1:0]    p_y,
    input  logic signed [COMPONENT_BITS-1:0]    p_z,
    input  logic signed [COMPONENT_BITS-1:0]    p_w,
    input  logic signed [COMPONENT_BITS-1:0]    q_x,
    input  logic signed [COMPONENT_BITS-1:0]    q_y,
    input  logic signed [COMPONENT_BITS-1:0]    q_z,
    input  logic signed [COMPONENT_BITS-1:0]    q_w,
    input  logic signed [COMPONENT_BITS-1:0]    factor,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COMPONENT_BITS-1:0]    r_x,
    output logic signed [COMPONENT_BITS-1:0]    r_y,
    output logic signed [COMPONENT_BITS-1:0]    r_z,
    output logic signed [COMPONENT_BITS-1:0]    r_w,
    output logic signed [2*COMPONENT_BITS-1:0]  dot_value,
    output logic                                saturated,
    output logic                                degenerate
);
    import qau_pkg::*;

    localparam int CB   = COMPONENT_BITS;
    localparam int FB   = FRACTION_BITS;
    localparam int PW   = 2 * CB;
    localparam int SW   = 2 * CB + 2;
    localparam int MW   = 2 * CB + 1;
    localparam int CW   = (MW > THRESH_W) ? MW : THRESH_W;
    localparam int XW   = MW + SQRT_SHIFT;
    localparam int RW   = (XW + 1) / 2;
    localparam int XP   = 2 * RW;
    localparam int REMW = RW + 2;
    localparam int NXW  = REMW + 2;
    localparam int DW   = (MW > RW) ? MW : RW;
    localparam int NA   = CB + FB + NORM_GUARD;
    localparam int NB   = (CB + 2 * FB > DW - 1) ? CB + 2 * FB : DW - 1;
    localparam int NW   = ((NA > NB) ? NA : NB) + 1;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [3:0][CB-1:0]   p;
        logic [3:0][CB-1:0]   q;
        logic [CB-1:0]        t;
        logic [PW-1:0]        dot;
        logic                 dsat;
        logic                 deg;
        logic [DW-1:0]        den;
        logic [3:0]           neg;
    } car_t;

    function automatic logic [CB-1:0] clip_c(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = $signed({{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}});
        lo = ~hi;
        if (v > hi)
            return hi[CB-1:0];
        else if (v < lo)
            return lo[CB-1:0];
        return v[CB-1:0];
    endfunction

    function automatic logic ovf_c(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = $signed({{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}});
        lo = ~hi;
        return (v > hi) || (v < lo);
    endfunction

    function automatic logic [PW-1:0] clip_d(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = $signed({{(SW-PW+1){1'b0}}, {(PW-1){1'b1}}});
        lo = ~hi;
        if (v > hi)
            return hi[PW-1:0];
        else if (v < lo)
            return lo[PW-1:0];
        return v[PW-1:0];
    endfunction

    function automatic logic ovf_d(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = $signed({{(SW-PW+1){1'b0}}, {(PW-1){1'b1}}});
        lo = ~hi;
        return (v > hi) || (v < lo);
    endfunction

    // round to nearest, ties away from zero, dropping FB fraction bits
    function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] v);
        logic [SW-1:0] mag;
        logic [SW-1:0] r;
        mag = v[SW-1] ? -v : v;
        r   = (mag + (SW'(1) << (FB - 1))) >> FB;
        return v[SW-1] ? -$signed(r) : $signed(r);
    endfunction

    logic en;
    logic [THRESH_W-1:0] thr_reg;

    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THRESH_RESET;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // ---------------- stage 1: input register
    car_t car1_next, car1_reg;
    logic v1_reg;

    always_comb
    begin
        car1_next      = '0;
        car1_next.op   = opcode;
        car1_next.p    = {p_w, p_z, p_y, p_x};
        car1_next.q    = {q_w, q_z, q_y, q_x};
        car1_next.t    = factor;
    end

    // ---------------- stage 2: products for dot and squared magnitude
    car_t car2_reg;
    logic v2_reg;
    logic signed [PW-1:0] dp_next  [4];
    logic signed [PW-1:0] dp_reg   [4];
    logic signed [PW-1:0] sqp_next [4];
    logic signed [PW-1:0] sqp_reg  [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic signed [CB-1:0] a;
            a = (car1_reg.op == OP_DIV) ? $signed(car1_reg.q[i]) : $signed(car1_reg.p[i]);
            dp_next[i]  = $signed(car1_reg.p[i]) * $signed(car1_reg.q[i]);
            sqp_next[i] = a * a;
        end
    end

    // ---------------- stage 3: sums
    car_t car3_reg;
    logic v3_reg;
    logic signed [SW-1:0] dsum_next, dsum_reg;
    logic [MW-1:0]        msum_next, msum_reg;

    always_comb
    begin
        dsum_next = SW'(dp_reg[0]) + SW'(dp_reg[1]) + SW'(dp_reg[2]) + SW'(dp_reg[3]);
        msum_next = MW'(sqp_reg[0]) + MW'(sqp_reg[1]) + MW'(sqp_reg[2]) + MW'(sqp_reg[3]);
    end

    // ---------------- stage 4 and square root stages
    car_t           sq_car_reg  [0:RW];
    logic           sq_v_reg    [0:RW];
    logic [XP-1:0]  sq_x_reg    [0:RW];
    logic [REMW-1:0] sq_rem_reg [0:RW];
    logic [RW-1:0]  sq_root_reg [0:RW];
    logic [XP-1:0]  sq_x_next   [0:RW];
    logic [REMW-1:0] sq_rem_next [0:RW];
    logic [RW-1:0]  sq_root_next [0:RW];
    car_t           sq0_car_next;

    always_comb
    begin
        logic mz;
        logic below;
        mz    = (msum_reg == '0);
        below = (CW'(msum_reg) < CW'(thr_reg));
        sq0_car_next      = car3_reg;
        sq0_car_next.dot  = clip_d(dsum_reg);
        sq0_car_next.dsat = ovf_d(dsum_reg);
        case (car3_reg.op) inside
            OP_NORM:        sq0_car_next.deg = mz || below;
            OP_INV, OP_DIV: sq0_car_next.deg = mz;
            default:        sq0_car_next.deg = 1'b0;
        endcase
        // zero magnitude divides by one
        sq0_car_next.den = mz ? (DW'(1) << (2 * FB)) : DW'(msum_reg);
        sq_x_next[0]    = XP'(msum_reg) << SQRT_SHIFT;
        sq_rem_next[0]  = '0;
        sq_root_next[0] = '0;
    end

    genvar k;
    generate
        for (k = 1; k <= RW; k++)
        begin : g_sqrt
            always_comb
            begin
                logic [NXW-1:0] nxt;
                logic [NXW-1:0] trial;
                logic           ge;
                nxt   = {sq_rem_reg[k-1], sq_x_reg[k-1][XP-1 -: 2]};
                trial = NXW'({sq_root_reg[k-1], 2'b01});
                ge    = (nxt >= trial);
                sq_rem_next[k]  = ge ? REMW'(nxt - trial) : REMW'(nxt);
                sq_root_next[k] = {sq_root_reg[k-1][RW-2:0], ge};
                sq_x_next[k]    = sq_x_reg[k-1] << 2;
            end
        end
    endgenerate

    // ---------------- divider setup and divider stages
    car_t            dv_car_reg [0:NW];
    logic            dv_v_reg   [0:NW];
    logic [DW-1:0]   dv_rem_reg [0:NW][4];
    logic [NW-1:0]   dv_nq_reg  [0:NW][4];
    logic [DW-1:0]   dv_rem_next [0:NW][4];
    logic [NW-1:0]   dv_nq_next  [0:NW][4];
    car_t            dv0_car_next;

    always_comb
    begin
        dv0_car_next = sq_car_reg[RW];
        if (sq_car_reg[RW].op == OP_NORM)
            dv0_car_next.den = DW'(sq_root_reg[RW]);
        for (int i = 0; i < 4; i++)
        begin
            logic signed [CB-1:0] a;
            logic [CB-1:0]        mag;
            logic [NW-1:0]        sh;
            a   = (sq_car_reg[RW].op == OP_DIV) ? $signed(sq_car_reg[RW].q[i])
                                                 : $signed(sq_car_reg[RW].p[i]);
            mag = a[CB-1] ? CB'(-a) : CB'(a);
            if (sq_car_reg[RW].op == OP_NORM)
            begin
                dv0_car_next.neg[i] = a[CB-1];
                sh = NW'(mag) << (FB + NORM_GUARD);
            end
            else
            begin
                // inverse negates the vector part
                dv0_car_next.neg[i] = (i == 3) ? a[CB-1] : (!a[CB-1] && (a != '0));
                sh = NW'(mag) << (2 * FB);
            end
            dv_nq_next[0][i]  = sh + NW'(dv0_car_next.den >> 1);
            dv_rem_next[0][i] = '0;
        end
    end

    generate
        for (k = 1; k <= NW; k++)
        begin : g_div
            always_comb
            begin
                for (int i = 0; i < 4; i++)
                begin
                    logic [DW:0] tr;
                    logic [DW:0] df;
                    logic        ge;
                    tr = {dv_rem_reg[k-1][i], dv_nq_reg[k-1][i][NW-1]};
                    df = tr - {1'b0, dv_car_reg[k-1].den};
                    ge = (tr >= {1'b0, dv_car_reg[k-1].den});
                    dv_rem_next[k][i] = ge ? df[DW-1:0] : tr[DW-1:0];
                    dv_nq_next[k][i]  = {dv_nq_reg[k-1][i][NW-2:0], ge};
                end
            end
        end
    endgenerate

    // ---------------- quotient sign and clip
    car_t          qs_car_reg;
    logic          qs_v_reg;
    logic [CB-1:0] qs_qi_next [4];
    logic [CB-1:0] qs_qi_reg  [4];
    logic          qs_isat_next, qs_isat_reg;

    always_comb
    begin
        qs_isat_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            logic [NW-1:0] qv;
            logic          big;
            qv  = dv_nq_reg[NW][i];
            big = ((qv >> (CB - 1)) != '0);
            if (dv_car_reg[NW].neg[i])
            begin
                if (big && (qv != (NW'(1) << (CB - 1))))
                begin
                    qs_qi_next[i] = {1'b1, {(CB-1){1'b0}}};
                    qs_isat_next  = 1'b1;
                end
                else
                    qs_qi_next[i] = -qv[CB-1:0];
            end
            else
            begin
                if (big)
                begin
                    qs_qi_next[i] = {1'b0, {(CB-1){1'b1}}};
                    qs_isat_next  = 1'b1;
                end
                else
                    qs_qi_next[i] = qv[CB-1:0];
            end
        end
    end

    // ---------------- product stage for Hamilton, scale and lerp
    car_t                 mu_car_reg;
    logic                 mu_v_reg;
    logic [CB-1:0]        mu_qi_reg [4];
    logic                 mu_isat_reg;
    logic signed [PW-1:0] hp_next [4][4];
    logic signed [PW-1:0] hp_reg  [4][4];
    logic signed [PW-1:0] sp_next [4];
    logic signed [PW-1:0] sp_reg  [4];
    logic signed [PW:0]   lp_next [4];
    logic signed [PW:0]   lp_reg  [4];

    always_comb
    begin
        logic signed [CB-1:0] a [4];
        logic signed [CB-1:0] b [4];
        for (int i = 0; i < 4; i++)
        begin
            logic signed [CB:0] diff;
            a[i] = (qs_car_reg.op == OP_DIV) ? $signed(qs_qi_reg[i]) : $signed(qs_car_reg.p[i]);
            b[i] = (qs_car_reg.op == OP_DIV) ? $signed(qs_car_reg.p[i]) : $signed(qs_car_reg.q[i]);
            diff = $signed(qs_car_reg.q[i]) - $signed(qs_car_reg.p[i]);
            sp_next[i] = $signed(qs_car_reg.p[i]) * $signed(qs_car_reg.t);
            lp_next[i] = $signed(qs_car_reg.t) * diff;
        end
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
                hp_next[i][j] = a[i] * b[j];
        end
    end

    // ---------------- final select, round and clip into the output register
    logic [CB-1:0] r_next [4];
    logic [CB-1:0] r_reg  [4];
    logic [PW-1:0] dot_reg;
    logic          sat_next, sat_reg;
    logic          deg_reg;
    logic          out_valid_reg;

    always_comb
    begin
        logic signed [SW-1:0] h [4];
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] pe;
        logic signed [SW-1:0] qe;
        logic                 use_clip;
        h[3] = SW'(hp_reg[3][3]) - SW'(hp_reg[0][0]) - SW'(hp_reg[1][1]) - SW'(hp_reg[2][2]);
        h[0] = SW'(hp_reg[3][0]) + SW'(hp_reg[0][3]) + SW'(hp_reg[1][2]) - SW'(hp_reg[2][1]);
        h[1] = SW'(hp_reg[3][1]) + SW'(hp_reg[1][3]) + SW'(hp_reg[2][0]) - SW'(hp_reg[0][2]);
        h[2] = SW'(hp_reg[3][2]) + SW'(hp_reg[2][3]) + SW'(hp_reg[0][1]) - SW'(hp_reg[1][0]);
        sat_next = mu_car_reg.dsat;
        case (mu_car_reg.op) inside
            OP_INV, OP_DIV: sat_next = sat_next | mu_isat_reg;
            OP_NORM:        sat_next = sat_next | (mu_isat_reg & !mu_car_reg.deg);
            default:        sat_next = sat_next;
        endcase
        for (int i = 0; i < 4; i++)
        begin
            pe       = SW'($signed(mu_car_reg.p[i]));
            qe       = SW'($signed(mu_car_reg.q[i]));
            v        = '0;
            use_clip = 1'b1;
            case (mu_car_reg.op) inside
                OP_ADD:         v = pe + qe;
                OP_SUB:         v = pe - qe;
                OP_MUL, OP_DIV: v = rnd(h[i]);
                OP_SCALE:       v = rnd(SW'(sp_reg[i]));
                OP_CLOSEST:     v = mu_car_reg.dot[PW-1] ? -pe : pe;
                OP_LERP:        v = rnd(SW'(lp_reg[i]) + (pe <<< FB));
                default:        use_clip = 1'b0;
            endcase
            if (use_clip)
            begin
                r_next[i] = clip_c(v);
                sat_next  = sat_next | ovf_c(v);
            end
            else if (mu_car_reg.op == OP_INV)
                r_next[i] = mu_qi_reg[i];
            else if (mu_car_reg.op == OP_NORM && !mu_car_reg.deg)
                r_next[i] = mu_qi_reg[i];
            else
                r_next[i] = '0;
        end
    end

    // ---------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            qs_v_reg      <= 1'b0;
            mu_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= RW; i++)
                sq_v_reg[i] <= 1'b0;
            for (int i = 0; i <= NW; i++)
                dv_v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            sq_v_reg[0]   <= v3_reg;
            for (int i = 1; i <= RW; i++)
                sq_v_reg[i] <= sq_v_reg[i-1];
            dv_v_reg[0]   <= sq_v_reg[RW];
            for (int i = 1; i <= NW; i++)
                dv_v_reg[i] <= dv_v_reg[i-1];
            qs_v_reg      <= dv_v_reg[NW];
            mu_v_reg      <= qs_v_reg;
            out_valid_reg <= mu_v_reg;
        end
    end

    // ---------------- payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            car1_reg <= car1_next;
            car2_reg <= car1_reg;
            dp_reg   <= dp_next;
            sqp_reg  <= sqp_next;
            car3_reg <= car2_reg;
            dsum_reg <= dsum_next;
            msum_reg <= msum_next;

            sq_car_reg[0]  <= sq0_car_next;
            sq_x_reg[0]    <= sq_x_next[0];
            sq_rem_reg[0]  <= sq_rem_next[0];
            sq_root_reg[0] <= sq_root_next[0];
            for (int i = 1; i <= RW; i++)
            begin
                sq_car_reg[i]  <= sq_car_reg[i-1];
                sq_x_reg[i]    <= sq_x_next[i];
                sq_rem_reg[i]  <= sq_rem_next[i];
                sq_root_reg[i] <= sq_root_next[i];
            end

            dv_car_reg[0] <= dv0_car_next;
            for (int i = 1; i <= NW; i++)
                dv_car_reg[i] <= dv_car_reg[i-1];
            for (int i = 0; i <= NW; i++)
            begin
                dv_rem_reg[i] <= dv_rem_next[i];
                dv_nq_reg[i]  <= dv_nq_next[i];
            end

            qs_car_reg  <= dv_car_reg[NW];
            qs_qi_reg   <= qs_qi_next;
            qs_isat_reg <= qs_isat_next;

            mu_car_reg  <= qs_car_reg;
            mu_qi_reg   <= qs_qi_reg;
            mu_isat_reg <= qs_isat_reg;
            hp_reg      <= hp_next;
            sp_reg      <= sp_next;
            lp_reg      <= lp_next;

            r_reg   <= r_next;
            dot_reg <= mu_car_reg.dot;
            sat_reg <= sat_next;
            deg_reg <= mu_car_reg.deg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign r_x        = r_reg[0];
    assign r_y        = r_reg[1];
    assign r_z        = r_reg[2];
    assign r_w        = r_reg[3];
    assign dot_value  = dot_reg;
    assign saturated  = sat_reg;
    assign degenerate = deg_reg;

endmodule
